FILE: hdl/cubic_bezier_tessellator_macros.svh
// assertion helpers used by the checker file
`ifndef CUBIC_BEZIER_TESSELLATOR_MACROS_SVH
`define CUBIC_BEZIER_TESSELLATOR_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define CBT_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// consequent must hold in the cycle after the antecedent
`define CBT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: hdl/cbt_pkg.sv
`default_nettype none
package cbt_pkg;

   // field widths
   localparam int COORD_W   = 32;
   localparam int SEG_W     = 7;
   localparam int LWID_W    = 31;
   localparam int FRAC_W    = 16;
   localparam int PARAM_W   = 17;
   localparam int WGT_W     = 18;
   localparam int CPROD_W   = 51;
   localparam int SPROD_W   = 36;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DAT_W = 32;
   localparam int DCNT_W    = 5;

   // constants
   localparam logic [SEG_W-1:0]   MIN_SEGMENTS     = 7'd20;
   localparam logic [SEG_W-1:0]   SEG_COUNT_RESET  = 7'd20;
   localparam logic [LWID_W-1:0]  LINE_WIDTH_RESET = 31'd65536;
   localparam logic [LWID_W-1:0]  LINE_WIDTH_ONE   = 31'd65536;
   localparam logic [PARAM_W-1:0] FX_ONE           = 17'h1_0000;
   localparam logic [1:0]         WGT_THREE        = 2'd3;
   localparam logic [DCNT_W-1:0]  DIV_STEPS        = 5'd17;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_SEGMENT_COUNT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LINE_WIDTH    = 2'd1;

   typedef logic signed [COORD_W-1:0] coord_type;

   localparam coord_type COORD_MAX = 32'sh7FFF_FFFF;
   localparam coord_type COORD_MIN = 32'sh8000_0000;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DIV,
      ST_TT,
      ST_UU,
      ST_UUU,
      ST_TTT,
      ST_W1,
      ST_W2,
      ST_C0,
      ST_C1,
      ST_C2,
      ST_C3,
      ST_CSUM,
      ST_COMMIT
   } state_type;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_TT,
      OP_UU,
      OP_UUU,
      OP_TTT,
      OP_W1,
      OP_W2,
      OP_C0,
      OP_C1,
      OP_C2,
      OP_C3
   } op_type;

   typedef enum logic [1:0] {
      ACC_NONE,
      ACC_LOAD,
      ACC_ADD
   } acc_type;

   // controller to datapath
   typedef struct packed {
      logic    load;
      logic    div_step;
      op_type  op;
      acc_type acc;
      logic    advance;
      logic    emit;
      logic    last;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic             div_done;
      logic             out_free;
      logic [SEG_W-1:0] n;
   } status_type;

   // q16.16 product rounded half up and saturated to 32 bits
   function automatic coord_type fx_round_sat(input logic signed [CPROD_W-1:0] prod);
      logic signed [CPROD_W-1:0]        biased;
      logic signed [CPROD_W-FRAC_W-1:0] q;
      biased = prod + 51'sd32768;
      q      = biased[CPROD_W-1:FRAC_W];
      if (q > 35'(COORD_MAX)) begin
         return COORD_MAX;
      end else if (q < 35'(COORD_MIN)) begin
         return COORD_MIN;
      end
      return q[COORD_W-1:0];
   endfunction

   // saturating 32-bit add
   function automatic coord_type sat_add(input coord_type a, input coord_type b);
      logic signed [COORD_W:0] s;
      s = 33'(a) + 33'(b);
      if (s > 33'(COORD_MAX)) begin
         return COORD_MAX;
      end else if (s < 33'(COORD_MIN)) begin
         return COORD_MIN;
      end
      return s[COORD_W-1:0];
   endfunction

endpackage
`default_nettype wire

FILE: hdl/cbt_ctrl.sv
`default_nettype none
module cbt_ctrl #(
   parameter int MAX_SEGMENTS = 64
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  cbt_pkg::status_type     status,
   output cbt_pkg::cmd_type        cmd
);
   import cbt_pkg::*;

   localparam int CNT_W = $clog2(MAX_SEGMENTS + 1);

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] idx_ff, idx_in;
   logic             is_last;

   // state and point index registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         idx_ff   <= '0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
      end
   end

   assign is_last = (idx_ff == CNT_W'(status.n));

   // next state and datapath commands
   always_comb begin
      state_in  = state_ff;
      idx_in    = idx_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               idx_in   = '0;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            if (status.div_done) begin
               state_in = ST_TT;
            end else begin
               cmd.div_step = 1'b1;
            end
         end
         ST_TT: begin
            cmd.op   = OP_TT;
            state_in = ST_UU;
         end
         ST_UU: begin
            cmd.op   = OP_UU;
            state_in = ST_UUU;
         end
         ST_UUU: begin
            cmd.op   = OP_UUU;
            state_in = ST_TTT;
         end
         ST_TTT: begin
            cmd.op   = OP_TTT;
            state_in = ST_W1;
         end
         ST_W1: begin
            cmd.op   = OP_W1;
            state_in = ST_W2;
         end
         ST_W2: begin
            cmd.op   = OP_W2;
            state_in = ST_C0;
         end
         ST_C0: begin
            cmd.op   = OP_C0;
            state_in = ST_C1;
         end
         ST_C1: begin
            cmd.op   = OP_C1;
            cmd.acc  = ACC_LOAD;
            state_in = ST_C2;
         end
         ST_C2: begin
            cmd.op   = OP_C2;
            cmd.acc  = ACC_ADD;
            state_in = ST_C3;
         end
         ST_C3: begin
            cmd.op   = OP_C3;
            cmd.acc  = ACC_ADD;
            state_in = ST_CSUM;
         end
         ST_CSUM: begin
            cmd.acc  = ACC_ADD;
            state_in = ST_COMMIT;
         end
         ST_COMMIT: begin
            // the point at t = 0 only seeds the segment start
            if (idx_ff == '0) begin
               cmd.advance = 1'b1;
               idx_in      = CNT_W'(idx_ff + 1'b1);
               state_in    = ST_TT;
            end else if (status.out_free) begin
               cmd.emit = 1'b1;
               cmd.last = is_last;
               if (is_last) begin
                  state_in = ST_IDLE;
               end else begin
                  cmd.advance = 1'b1;
                  idx_in      = CNT_W'(idx_ff + 1'b1);
                  state_in    = ST_TT;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule
`default_nettype wire

FILE: hdl/cbt_dp.sv
`default_nettype none
module cbt_dp #(
   parameter int MAX_SEGMENTS = 64
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  cbt_pkg::cmd_type                        cmd,
   output cbt_pkg::status_type                     status,
   input  wire logic signed [cbt_pkg::COORD_W-1:0] req_p0x,
   input  wire logic signed [cbt_pkg::COORD_W-1:0] req_p0y,
   input  wire logic signed [cbt_pkg::COORD_W-1:0] req_p1x,
   input  wire logic signed [cbt_pkg::COORD_W-1:0] req_p1y,
   input  wire logic signed [cbt_pkg::COORD_W-1:0] req_p2x,
   input  wire logic signed [cbt_pkg::COORD_W-1:0] req_p2y,
   input  wire logic signed [cbt_pkg::COORD_W-1:0] req_p3x,
   input  wire logic signed [cbt_pkg::COORD_W-1:0] req_p3y,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_ready,
   output logic signed [cbt_pkg::COORD_W-1:0]      rsp_seg_start_x,
   output logic signed [cbt_pkg::COORD_W-1:0]      rsp_seg_start_y,
   output logic signed [cbt_pkg::COORD_W-1:0]      rsp_seg_end_x,
   output logic signed [cbt_pkg::COORD_W-1:0]      rsp_seg_end_y,
   output logic [cbt_pkg::LWID_W-1:0]              rsp_width_out,
   output logic                                    rsp_last,
   input  wire logic                               csr_valid,
   output logic                                    csr_ready,
   input  wire logic [cbt_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire logic [cbt_pkg::CSR_DAT_W-1:0]      csr_wdata
);
   import cbt_pkg::*;

   localparam logic [SEG_W-1:0] MAX_SEG = SEG_W'(MAX_SEGMENTS);

   // configuration
   logic [SEG_W-1:0]  seg_count_ff;
   logic [LWID_W-1:0] line_width_ff;

   // per-curve registers
   coord_type         px_ff [4];
   coord_type         py_ff [4];
   logic [SEG_W-1:0]  n_ff;
   logic [SEG_W-1:0]  n_eff;
   logic [LWID_W-1:0] width_ff;

   // divider for 65536 / n
   logic [PARAM_W-1:0] dvd_ff;
   logic [SEG_W-1:0]   rem_ff;
   logic [DCNT_W-1:0]  dcnt_ff;
   logic [SEG_W:0]     rem_sh;
   logic               rem_ge;

   // parameter t and its remainder
   logic [PARAM_W-1:0] t_ff;
   logic [SEG_W-1:0]   r_ff;
   logic [PARAM_W-1:0] u;
   logic [SEG_W:0]     r_sum;
   logic               r_wrap;

   // weights
   logic [WGT_W-1:0]   tt_ff, uu_ff, uuu_ff, ttt_ff, w1_ff, w2_ff;
   logic [WGT_W-1:0]   sm_a, sm_b, sm_res;
   logic [SPROD_W-1:0] sm_prod;

   // coordinate products and sums
   logic [WGT_W-1:0]          cw;
   coord_type                 cpx, cpy;
   logic signed [CPROD_W-1:0] cprod_x, cprod_y;
   coord_type                 prod_x_ff, prod_y_ff;
   coord_type                 acc_x_ff, acc_y_ff;
   coord_type                 prev_x_ff, prev_y_ff;

   assign csr_ready = 1'b1;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         seg_count_ff  <= SEG_COUNT_RESET;
         line_width_ff <= LINE_WIDTH_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_SEGMENT_COUNT: seg_count_ff  <= csr_wdata[SEG_W-1:0];
            CSR_LINE_WIDTH:    line_width_ff <= csr_wdata[LWID_W-1:0];
            default: ;
         endcase
      end
   end

   // effective segment count
   always_comb begin
      if (seg_count_ff < MIN_SEGMENTS) begin
         n_eff = MIN_SEGMENTS;
      end else if (seg_count_ff > MAX_SEG) begin
         n_eff = MAX_SEG;
      end else begin
         n_eff = seg_count_ff;
      end
   end

   // capture the curve
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         px_ff[0] <= req_p0x;
         py_ff[0] <= req_p0y;
         px_ff[1] <= req_p1x;
         py_ff[1] <= req_p1y;
         px_ff[2] <= req_p2x;
         py_ff[2] <= req_p2y;
         px_ff[3] <= req_p3x;
         py_ff[3] <= req_p3y;
         n_ff     <= n_eff;
         width_ff <= (line_width_ff == '0) ? LINE_WIDTH_ONE : line_width_ff;
      end
   end

   // restoring divider, one quotient bit per cycle
   assign rem_sh = {rem_ff, dvd_ff[PARAM_W-1]};
   assign rem_ge = (rem_sh >= {1'b0, n_ff});

   always_ff @(posedge clock) begin
      if (reset) begin
         dcnt_ff <= '0;
      end else if (cmd.load) begin
         dcnt_ff <= DIV_STEPS;
      end else if (cmd.div_step) begin
         dcnt_ff <= dcnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         dvd_ff <= FX_ONE;
         rem_ff <= '0;
      end else if (cmd.div_step) begin
         dvd_ff <= {dvd_ff[PARAM_W-2:0], rem_ge};
         rem_ff <= rem_ge ? SEG_W'(rem_sh - {1'b0, n_ff}) : rem_sh[SEG_W-1:0];
      end
   end

   // t steps by the quotient, carrying the remainder
   assign u      = FX_ONE - t_ff;
   assign r_sum  = {1'b0, r_ff} + {1'b0, rem_ff};
   assign r_wrap = (r_sum >= {1'b0, n_ff});

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         t_ff <= '0;
         r_ff <= n_eff >> 1;
      end else if (cmd.advance) begin
         t_ff <= t_ff + dvd_ff + PARAM_W'(r_wrap);
         r_ff <= r_wrap ? SEG_W'(r_sum - {1'b0, n_ff}) : r_sum[SEG_W-1:0];
      end
   end

   // shared weight multiplier operand select
   always_comb begin
      sm_a = '0;
      sm_b = '0;
      case (cmd.op)
         OP_TT: begin
            sm_a = WGT_W'(t_ff);
            sm_b = WGT_W'(t_ff);
         end
         OP_UU: begin
            sm_a = WGT_W'(u);
            sm_b = WGT_W'(u);
         end
         OP_UUU: begin
            sm_a = uu_ff;
            sm_b = WGT_W'(u);
         end
         OP_TTT: begin
            sm_a = tt_ff;
            sm_b = WGT_W'(t_ff);
         end
         OP_W1: begin
            sm_a = uu_ff * WGT_THREE;
            sm_b = WGT_W'(t_ff);
         end
         OP_W2: begin
            sm_a = WGT_W'(u) * WGT_THREE;
            sm_b = tt_ff;
         end
         default: ;
      endcase
   end

   // weights stay non-negative and below 3.0, so no saturation is needed
   assign sm_prod = SPROD_W'(sm_a) * SPROD_W'(sm_b) + SPROD_W'(32768);
   assign sm_res  = sm_prod[FRAC_W+WGT_W-1:FRAC_W];

   always_ff @(posedge clock) begin
      case (cmd.op)
         OP_TT:  tt_ff  <= sm_res;
         OP_UU:  uu_ff  <= sm_res;
         OP_UUU: uuu_ff <= sm_res;
         OP_TTT: ttt_ff <= sm_res;
         OP_W1:  w1_ff  <= sm_res;
         OP_W2:  w2_ff  <= sm_res;
         default: ;
      endcase
   end

   // coordinate multiplier operand select, x and y side by side
   always_comb begin
      cw  = '0;
      cpx = px_ff[0];
      cpy = py_ff[0];
      case (cmd.op)
         OP_C0: begin
            cw  = uuu_ff;
            cpx = px_ff[0];
            cpy = py_ff[0];
         end
         OP_C1: begin
            cw  = w1_ff;
            cpx = px_ff[1];
            cpy = py_ff[1];
         end
         OP_C2: begin
            cw  = w2_ff;
            cpx = px_ff[2];
            cpy = py_ff[2];
         end
         OP_C3: begin
            cw  = ttt_ff;
            cpx = px_ff[3];
            cpy = py_ff[3];
         end
         default: ;
      endcase
   end

   assign cprod_x = $signed({{(CPROD_W-WGT_W){1'b0}}, cw})
                  * $signed({{(CPROD_W-COORD_W){cpx[COORD_W-1]}}, cpx});
   assign cprod_y = $signed({{(CPROD_W-WGT_W){1'b0}}, cw})
                  * $signed({{(CPROD_W-COORD_W){cpy[COORD_W-1]}}, cpy});

   // rounded products are registered, then feed the saturating running sum
   always_ff @(posedge clock) begin
      prod_x_ff <= fx_round_sat(cprod_x);
      prod_y_ff <= fx_round_sat(cprod_y);
      case (cmd.acc)
         ACC_LOAD: begin
            acc_x_ff <= prod_x_ff;
            acc_y_ff <= prod_y_ff;
         end
         ACC_ADD: begin
            acc_x_ff <= sat_add(acc_x_ff, prod_x_ff);
            acc_y_ff <= sat_add(acc_y_ff, prod_y_ff);
         end
         default: ;
      endcase
   end

   // previous point becomes the next segment start
   always_ff @(posedge clock) begin
      if (cmd.advance) begin
         prev_x_ff <= acc_x_ff;
         prev_y_ff <= acc_y_ff;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_seg_start_x <= prev_x_ff;
         rsp_seg_start_y <= prev_y_ff;
         rsp_seg_end_x   <= acc_x_ff;
         rsp_seg_end_y   <= acc_y_ff;
         rsp_width_out   <= width_ff;
         rsp_last        <= cmd.last;
      end
   end

   // status back to the controller
   assign status.div_done = (dcnt_ff == '0);
   assign status.out_free = !rsp_valid || rsp_ready;
   assign status.n        = n_ff;

endmodule
`default_nettype wire

FILE: hdl/cubic_bezier_tessellator.sv
// channel   direction  payload
// req       in         p0x p0y p1x p1y p2x p2y p3x p3y, signed q16.16
// rsp       out        seg_start_x/y seg_end_x/y width_out last
// csr       in         csr_index, csr_wdata (0 segment_count, 1 line_width)
//
// for N effective segments, one curve with rsp ready goes through the accept, the divider
// (17 quotient bits and a done check), then for each of its N + 1 points the shared weight
// multiplier and the four-term sum
// synchronous active-high reset clears control state and both registers
// a stalled rsp holds only the output register; the next point is computed
// behind it, and a new curve is taken once the last segment is registered
`default_nettype none
module cubic_bezier_tessellator #(
   parameter int MAX_SEGMENTS = 64
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   output logic                                    req_ready,
   input  wire logic signed [cbt_pkg::COORD_W-1:0] req_p0x,
   input  wire logic signed [cbt_pkg::COORD_W-1:0] req_p0y,
   input  wire logic signed [cbt_pkg::COORD_W-1:0] req_p1x,
   input  wire logic signed [cbt_pkg::COORD_W-1:0] req_p1y,
   input  wire logic signed [cbt_pkg::COORD_W-1:0] req_p2x,
   input  wire logic signed [cbt_pkg::COORD_W-1:0] req_p2y,
   input  wire logic signed [cbt_pkg::COORD_W-1:0] req_p3x,
   input  wire logic signed [cbt_pkg::COORD_W-1:0] req_p3y,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_ready,
   output logic signed [cbt_pkg::COORD_W-1:0]      rsp_seg_start_x,
   output logic signed [cbt_pkg::COORD_W-1:0]      rsp_seg_start_y,
   output logic signed [cbt_pkg::COORD_W-1:0]      rsp_seg_end_x,
   output logic signed [cbt_pkg::COORD_W-1:0]      rsp_seg_end_y,
   output logic [cbt_pkg::LWID_W-1:0]              rsp_width_out,
   output logic                                    rsp_last,
   input  wire logic                               csr_valid,
   output logic                                    csr_ready,
   input  wire logic [cbt_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire logic [cbt_pkg::CSR_DAT_W-1:0]      csr_wdata
);
   import cbt_pkg::*;

   cmd_type    cmd;
   status_type status;

   // sequencer
   cbt_ctrl #(
      .MAX_SEGMENTS (MAX_SEGMENTS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // arithmetic, configuration and output register
   cbt_dp #(
      .MAX_SEGMENTS (MAX_SEGMENTS)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_p0x         (req_p0x),
      .req_p0y         (req_p0y),
      .req_p1x         (req_p1x),
      .req_p1y         (req_p1y),
      .req_p2x         (req_p2x),
      .req_p2y         (req_p2y),
      .req_p3x         (req_p3x),
      .req_p3y         (req_p3y),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_seg_start_x (rsp_seg_start_x),
      .rsp_seg_start_y (rsp_seg_start_y),
      .rsp_seg_end_x   (rsp_seg_end_x),
      .rsp_seg_end_y   (rsp_seg_end_y),
      .rsp_width_out   (rsp_width_out),
      .rsp_last        (rsp_last),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

endmodule
`default_nettype wire

FILE: hdl/cbt_checker.sv
`default_nettype none
`include "cubic_bezier_tessellator_macros.svh"
module cbt_checker (
   input wire logic                               clock,
   input wire logic                               reset,
   input wire logic                               req_valid,
   input wire logic                               req_ready,
   input wire logic                               rsp_valid,
   input wire logic                               rsp_ready,
   input wire logic signed [cbt_pkg::COORD_W-1:0] rsp_seg_start_x,
   input wire logic signed [cbt_pkg::COORD_W-1:0] rsp_seg_start_y,
   input wire logic signed [cbt_pkg::COORD_W-1:0] rsp_seg_end_x,
   input wire logic signed [cbt_pkg::COORD_W-1:0] rsp_seg_end_y,
   input wire logic [cbt_pkg::LWID_W-1:0]         rsp_width_out,
   input wire logic                               rsp_last
);

   logic [4*cbt_pkg::COORD_W+cbt_pkg::LWID_W:0] rsp_payload;

   // whole rsp payload as one vector
   assign rsp_payload = {rsp_seg_start_x, rsp_seg_start_y, rsp_seg_end_x, rsp_seg_end_y,
                         rsp_width_out, rsp_last};

   // a stalled segment keeps its payload
   `CBT_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_payload), "rsp changed while stalled")

   // effective width is never zero
   `CBT_ASSERT_SAME(a_width_nonzero, clock, reset, rsp_valid, rsp_width_out != '0, "zero line width on rsp")

   // no new curve while a segment before the last one is pending
   `CBT_ASSERT_SAME(a_no_req_mid_curve, clock, reset, rsp_valid && !rsp_last, !req_ready, "req_ready mid curve")

   // a curve in work blocks the next one
   `CBT_ASSERT_NEXT(a_busy_after_req, clock, reset, req_valid && req_ready, !req_ready, "req_ready after accept")

endmodule

bind cubic_bezier_tessellator cbt_checker u_cbt_checker (.*);
`default_nettype wire
